@@ rtl/spod_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted pair offload decider package
// Shared widths, reset values, state encodings and the control structs that
// pass between the sorting row, the evaluator and the top level.
// ----------------------------------------------------------------------------
package spod_pkg;

  localparam int unsigned LOAD_W        = 16;
  localparam int unsigned OWN_W         = 6;
  localparam int unsigned ABS_W         = 16;
  localparam int unsigned REL_W         = 17;
  localparam int unsigned TASK_W        = 16;
  localparam int unsigned Q_SHIFT       = 16;
  localparam int unsigned PROD_W        = REL_W + LOAD_W;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned DEF_MAX_RANKS = 64;

  localparam logic [OWN_W-1:0] OWN_RANK_RST = '0;
  localparam logic [ABS_W-1:0] MIN_ABS_RST  = ABS_W'(2);
  localparam logic [REL_W-1:0] MIN_REL_RST  = REL_W'(6554);
  localparam logic [REL_W-1:0] FRAC_RST     = REL_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_RANK   = 3'd0,
    CFG_MIN_ABS    = 3'd1,
    CFG_MIN_REL    = 3'd2,
    CFG_FRACTION   = 3'd3,
    CFG_FORCE      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_PICK,
    S_EVAL,
    S_SKIP
  } ctrl_state_t;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_MAX,
    EV_CUR,
    EV_FRAC,
    EV_DONE
  } eval_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [LOAD_W-1:0] load;
  } cell_ctl_t;

  typedef struct packed {
    logic [ABS_W-1:0] min_abs;
    logic [REL_W-1:0] min_rel;
    logic [REL_W-1:0] fraction;
    logic             force_mig;
  } eval_cfg_t;

  typedef struct packed {
    logic              go;
    logic [LOAD_W-1:0] cur;
    logic [LOAD_W-1:0] other;
    logic [LOAD_W-1:0] lo_load;
    logic [LOAD_W-1:0] hi_load;
    logic              upper_half;
  } eval_req_t;

  typedef struct packed {
    logic              done;
    logic              offload;
    logic [TASK_W-1:0] task_count;
  } eval_res_t;

endpackage
`default_nettype wire

@@ rtl/sorted_pair_offload_decider_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted pair offload decider
// Collects one load per rank into a sorted row of cells, then picks the rank
// at the mirrored sorted position and decides whether and how much to offload.
//
//   Channel   Handshake              Payload
//   input     start, busy            in_load, in_last
//   result    out_valid (1 cycle)    out_offload, out_target_rank, out_task_count
//   config    cfg_we                 cfg_idx, cfg_wdata
//
// An item without in_last is sorted into the row on entry; busy stays low, so the block is ready for the next item.
// After the last item of a round (n loads) the row rotates through all n entries
// to find the own rank's position, then on to the mirrored position, and the
// evaluator runs its products through its shared multiplier.
// With own_rank not below n the round passes S_SKIP and reports no offload.
// Reset clears the row and the round statistics at once. The result is shown
// for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_pair_offload_decider_core #(
  parameter int unsigned MAX_RANKS = spod_pkg::DEF_MAX_RANKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [spod_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [spod_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic [spod_pkg::LOAD_W-1:0]       in_load,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic                              out_offload,
  output logic [spod_pkg::OWN_W-1:0]        out_target_rank,
  output logic [spod_pkg::TASK_W-1:0]       out_task_count
);
  import spod_pkg::*;

  localparam int unsigned RANK_W = $clog2(MAX_RANKS);
  localparam int unsigned CNT_W  = $clog2(MAX_RANKS + 1);
  localparam int unsigned IDW    = (RANK_W > OWN_W) ? RANK_W : OWN_W;
  localparam int unsigned NW     = (CNT_W > OWN_W) ? CNT_W : OWN_W;

  ctrl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [LOAD_W-1:0] min_r, min_nxt;
  logic [LOAD_W-1:0] max_r, max_nxt;
  logic [LOAD_W-1:0] cur_r, cur_nxt;
  logic [LOAD_W-1:0] other_r, other_nxt;
  logic [RANK_W-1:0] other_rank_r, other_rank_nxt;

  logic [OWN_W-1:0]  own_r;
  logic [ABS_W-1:0]  min_abs_r;
  logic [REL_W-1:0]  min_rel_r;
  logic [REL_W-1:0]  fraction_r;
  logic              force_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_offload_r, out_offload_nxt;
  logic [OWN_W-1:0]  out_target_r, out_target_nxt;
  logic [TASK_W-1:0] out_count_r, out_count_nxt;

  logic              accept, has_room, finish;
  logic [CNT_W-1:0]  n_new, last_idx;
  cell_ctl_t         row_ctl;
  eval_cfg_t         ev_cfg;
  eval_req_t         ev_req;
  eval_res_t         ev_res;

  logic [LOAD_W-1:0] c_load  [MAX_RANKS];
  logic [RANK_W-1:0] c_rank  [MAX_RANKS];
  logic              c_valid [MAX_RANKS];
  logic              c_keep  [MAX_RANKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r      <= OWN_RANK_RST;
      min_abs_r  <= MIN_ABS_RST;
      min_rel_r  <= MIN_REL_RST;
      fraction_r <= FRAC_RST;
      force_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OWN_RANK: own_r      <= cfg_wdata[OWN_W-1:0];
        CFG_MIN_ABS:  min_abs_r  <= cfg_wdata[ABS_W-1:0];
        CFG_MIN_REL:  min_rel_r  <= cfg_wdata[REL_W-1:0];
        CFG_FRACTION: fraction_r <= cfg_wdata[REL_W-1:0];
        CFG_FORCE:    force_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign last_idx = n_r - CNT_W'(1);

  for (genvar k = 0; k < MAX_RANKS; k++) begin : g_row
    logic [LOAD_W-1:0] lft_load, rgt_load;
    logic [RANK_W-1:0] lft_rank, rgt_rank;
    logic              lft_valid, lft_keep, rgt_valid;

    if (k == 0) begin : g_first
      assign lft_load  = '0;
      assign lft_rank  = '0;
      assign lft_valid = 1'b0;
      assign lft_keep  = 1'b1;
    end else begin : g_inner_l
      assign lft_load  = c_load[k-1];
      assign lft_rank  = c_rank[k-1];
      assign lft_valid = c_valid[k-1];
      assign lft_keep  = c_keep[k-1];
    end

    if (k == MAX_RANKS - 1) begin : g_end
      assign rgt_load  = '0;
      assign rgt_rank  = '0;
      assign rgt_valid = 1'b0;
    end else begin : g_inner_r
      assign rgt_load  = c_load[k+1];
      assign rgt_rank  = c_rank[k+1];
      assign rgt_valid = c_valid[k+1];
    end

    spod_cell #(
      .RANK_W (RANK_W),
      .CNT_W  (CNT_W),
      .IDX    (k)
    ) u_slot (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (row_ctl),
      .new_rank    (cnt_r[RANK_W-1:0]),
      .last_idx    (last_idx),
      .left_load   (lft_load),
      .left_rank   (lft_rank),
      .left_valid  (lft_valid),
      .left_keep   (lft_keep),
      .right_load  (rgt_load),
      .right_rank  (rgt_rank),
      .right_valid (rgt_valid),
      .head_load   (c_load[0]),
      .head_rank   (c_rank[0]),
      .head_valid  (c_valid[0]),
      .load        (c_load[k]),
      .rank        (c_rank[k]),
      .valid       (c_valid[k]),
      .keep        (c_keep[k])
    );
  end

  assign ev_cfg.min_abs   = min_abs_r;
  assign ev_cfg.min_rel   = min_rel_r;
  assign ev_cfg.fraction  = fraction_r;
  assign ev_cfg.force_mig = force_r;

  assign ev_req.go         = (state_r == S_EVAL);
  assign ev_req.cur        = cur_r;
  assign ev_req.other      = other_r;
  assign ev_req.lo_load    = min_r;
  assign ev_req.hi_load    = max_r;
  assign ev_req.upper_half = ({pos_r, 1'b0} >= {1'b0, n_r});

  spod_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (ev_cfg),
    .req   (ev_req),
    .res   (ev_res)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign has_room = cnt_r < CNT_W'(MAX_RANKS);
  assign n_new    = has_room ? (cnt_r + CNT_W'(1)) : cnt_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    min_nxt         = min_r;
    max_nxt         = max_r;
    cur_nxt         = cur_r;
    other_nxt       = other_r;
    other_rank_nxt  = other_rank_r;
    out_valid_nxt   = 1'b0;
    out_offload_nxt = out_offload_r;
    out_target_nxt  = out_target_r;
    out_count_nxt   = out_count_r;
    row_ctl.op      = CELL_HOLD;
    row_ctl.load    = in_load;
    finish          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (has_room) begin
            row_ctl.op = CELL_INSERT;
            cnt_nxt    = cnt_r + CNT_W'(1);
            if (in_load < min_r) begin
              min_nxt = in_load;
            end
            if (in_load > max_r) begin
              max_nxt = in_load;
            end
          end
          if (in_last) begin
            n_nxt   = n_new;
            idx_nxt = '0;
            if (NW'(own_r) < NW'(n_new)) begin
              state_nxt = S_FIND;
            end else begin
              state_nxt = S_SKIP;
            end
          end
        end
      end
      S_FIND: begin
        row_ctl.op = CELL_ROTATE;
        if (c_valid[0] && (IDW'(c_rank[0]) == IDW'(own_r))) begin
          pos_nxt = idx_r;
          cur_nxt = c_load[0];
        end
        if (idx_r == last_idx) begin
          idx_nxt   = '0;
          state_nxt = S_PICK;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_PICK: begin
        row_ctl.op = CELL_ROTATE;
        if (idx_r == last_idx - pos_r) begin
          other_nxt      = c_load[0];
          other_rank_nxt = c_rank[0];
          state_nxt      = S_EVAL;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_EVAL: begin
        if (ev_res.done) begin
          finish          = 1'b1;
          out_offload_nxt = ev_res.offload;
          out_target_nxt  = ev_res.offload ? OWN_W'(other_rank_r) : '0;
          out_count_nxt   = ev_res.task_count;
        end
      end
      S_SKIP: begin
        finish          = 1'b1;
        out_offload_nxt = 1'b0;
        out_target_nxt  = '0;
        out_count_nxt   = '0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt = 1'b1;
      row_ctl.op    = CELL_CLEAR;
      cnt_nxt       = '0;
      min_nxt       = '1;
      max_nxt       = '0;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    cur_r         <= cur_nxt;
    other_r       <= other_nxt;
    other_rank_r  <= other_rank_nxt;
    out_offload_r <= out_offload_nxt;
    out_target_r  <= out_target_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_offload     = out_offload_r;
  assign out_target_rank = out_target_r;
  assign out_task_count  = out_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RANKS))
    else $error("rank count exceeds the row length");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_SKIP || state_r == S_EVAL))
    else $error("result strobe without a finished round");

  a_no_offload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_offload_r) |-> (out_task_count == '0 && out_target_rank == '0))
    else $error("no-offload result carries a target or a count");

  a_offload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_offload_r) |-> (out_task_count != '0))
    else $error("offload result with zero tasks");

endmodule
`default_nettype wire

@@ rtl/spod_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorting row cell
// Holds one load with its rank index. On insert it keeps its entry, takes the
// new one or takes its left neighbor's, so the row stays sorted ascending.
// On rotate it takes its right neighbor's entry, wrapping to the head.
// ----------------------------------------------------------------------------
module spod_cell #(
  parameter int unsigned RANK_W = 6,
  parameter int unsigned CNT_W  = 7,
  parameter int unsigned IDX    = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spod_pkg::cell_ctl_t            ctl,
  input  logic [RANK_W-1:0]              new_rank,
  input  logic [CNT_W-1:0]               last_idx,
  input  logic [spod_pkg::LOAD_W-1:0]    left_load,
  input  logic [RANK_W-1:0]              left_rank,
  input  logic                           left_valid,
  input  logic                           left_keep,
  input  logic [spod_pkg::LOAD_W-1:0]    right_load,
  input  logic [RANK_W-1:0]              right_rank,
  input  logic                           right_valid,
  input  logic [spod_pkg::LOAD_W-1:0]    head_load,
  input  logic [RANK_W-1:0]              head_rank,
  input  logic                           head_valid,
  output logic [spod_pkg::LOAD_W-1:0]    load,
  output logic [RANK_W-1:0]              rank,
  output logic                           valid,
  output logic                           keep
);
  import spod_pkg::*;

  logic [LOAD_W-1:0] load_r, load_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              valid_r, valid_nxt;
  logic              wrap;

  assign keep = valid_r && (load_r <= ctl.load);
  assign wrap = (CNT_W'(IDX) == last_idx);

  always_comb begin
    load_nxt  = load_r;
    rank_nxt  = rank_r;
    valid_nxt = valid_r;
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            load_nxt  = ctl.load;
            rank_nxt  = new_rank;
            valid_nxt = 1'b1;
          end else begin
            load_nxt  = left_load;
            rank_nxt  = left_rank;
            valid_nxt = left_valid;
          end
        end
      end
      CELL_ROTATE: begin
        if (wrap) begin
          load_nxt  = head_load;
          rank_nxt  = head_rank;
          valid_nxt = head_valid;
        end else begin
          load_nxt  = right_load;
          rank_nxt  = right_rank;
          valid_nxt = right_valid;
        end
      end
      CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    load_r <= load_nxt;
    rank_r <= rank_nxt;
  end

  assign load  = load_r;
  assign rank  = rank_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

@@ rtl/spod_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Offload evaluator
// Runs the three Q1.16 products through one shared multiplier, one per cycle,
// then applies the imbalance checks and forms the saturated task count.
// ----------------------------------------------------------------------------
module spod_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spod_pkg::eval_cfg_t  cfg,
  input  spod_pkg::eval_req_t  req,
  output spod_pkg::eval_res_t  res
);
  import spod_pkg::*;

  localparam int unsigned QUO_W = PROD_W - Q_SHIFT;

  eval_state_t       state_r, state_nxt;
  logic [REL_W-1:0]  mul_a;
  logic [LOAD_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] pmax_r, pcur_r, pfrac_r;
  logic [LOAD_W-1:0] diff, span, above_min;
  logic              gt, abs_ok, rel_ok, pair_abs_ok, pair_rel_ok, ok;
  logic [QUO_W-1:0]  quo;
  logic [TASK_W-1:0] num;

  assign diff = req.cur - req.other;
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt = state_r;
    mul_a     = cfg.min_rel;
    mul_b     = req.hi_load;
    unique case (state_r)
      EV_IDLE: begin
        if (req.go) begin
          state_nxt = EV_MAX;
        end
      end
      EV_MAX: begin
        state_nxt = EV_CUR;
      end
      EV_CUR: begin
        mul_b     = req.cur;
        state_nxt = EV_FRAC;
      end
      EV_FRAC: begin
        mul_a     = cfg.fraction;
        mul_b     = diff;
        state_nxt = EV_DONE;
      end
      EV_DONE: begin
        state_nxt = EV_IDLE;
      end
      default: begin
        state_nxt = EV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == EV_MAX) begin
      pmax_r <= prod;
    end
    if (state_r == EV_CUR) begin
      pcur_r <= prod;
    end
    if (state_r == EV_FRAC) begin
      pfrac_r <= prod;
    end
  end

  always_comb begin
    gt          = req.other < req.cur;
    above_min   = req.cur - req.lo_load;
    span        = req.hi_load - req.lo_load;
    abs_ok      = ABS_W'(above_min) >= cfg.min_abs;
    if (req.hi_load == '0) begin
      rel_ok = (cfg.min_rel == '0);
    end else begin
      rel_ok = PROD_W'({span, {Q_SHIFT{1'b0}}}) >= pmax_r;
    end
    pair_abs_ok = !(req.other > req.cur) && (ABS_W'(diff) >= cfg.min_abs);
    pair_rel_ok = gt && (PROD_W'({diff, {Q_SHIFT{1'b0}}}) >= pcur_r);
    ok = cfg.force_mig ||
         (abs_ok && rel_ok && req.upper_half && pair_abs_ok && pair_rel_ok);
    quo = pfrac_r[PROD_W-1:Q_SHIFT];
    if (!gt || quo == '0) begin
      num = TASK_W'(1);
    end else if (|quo[QUO_W-1:TASK_W]) begin
      num = '1;
    end else begin
      num = quo[TASK_W-1:0];
    end
  end

  assign res.done       = (state_r == EV_DONE);
  assign res.offload    = ok;
  assign res.task_count = ok ? num : '0;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the sorted pair offload decider
// Sends rounds of per-rank loads through the start/busy port and predicts the
// decision of every round. For each closing item, the predictor ranks the
// loads, finds the mirrored rank and applies the same threshold checks as the
// block. Every strobed result is compared field by field with the oldest
// prediction. Directed rounds cover extreme loads and settings, forced
// migration, an own rank past the round size and store overflow. Random phases
// then change the settings between batches of rounds.
// ----------------------------------------------------------------------------
module tb_top;
  import spod_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 16;

  typedef struct packed {
    logic              offload;
    logic [OWN_W-1:0]  target;
    logic [TASK_W-1:0] tasks;
  } decision_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  logic [LOAD_W-1:0]     in_load   = '0;
  logic                  in_last   = 1'b0;
  logic                  out_valid;
  logic                  out_offload;
  logic [OWN_W-1:0]      out_target_rank;
  logic [TASK_W-1:0]     out_task_count;

  // Predictor copy of the round state and the settings.
  logic [LOAD_W-1:0] rank_loads [DEF_MAX_RANKS];
  int unsigned       ranks_seen;
  logic [LOAD_W-1:0] round_min;
  logic [LOAD_W-1:0] round_max;
  logic [OWN_W-1:0]  own_rank_q;
  logic [ABS_W-1:0]  min_abs_q;
  logic [REL_W-1:0]  min_rel_q;
  logic [REL_W-1:0]  fraction_q;
  logic              force_q;

  decision_t   pending_decisions [$];
  int unsigned errors      = 0;
  int unsigned stall_cycles = 0;
  bit          steady_feed = 1'b0;

  sorted_pair_offload_decider_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_load        (in_load),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_offload    (out_offload),
    .out_target_rank(out_target_rank),
    .out_task_count (out_task_count)
  );

  always #6 clk = ~clk;

  function automatic void clear_round();
    ranks_seen = 0;
    round_min  = '1;
    round_max  = '0;
  endfunction

  function automatic int unsigned sorted_slot(int unsigned r, int unsigned n);
    int unsigned p;
    p = 0;
    for (int unsigned j = 0; j < n; j++) begin
      if (rank_loads[j] < rank_loads[r] || (rank_loads[j] == rank_loads[r] && j < r)) p++;
    end
    return p;
  endfunction

  function automatic decision_t decide_round();
    decision_t       d;
    int unsigned     n;
    int unsigned     pos;
    int unsigned     mirror;
    longint unsigned cur_l;
    longint unsigned oth_l;
    longint unsigned min_l;
    longint unsigned max_l;
    longint unsigned num;
    bit              ok;
    d = '0;
    n = ranks_seen;
    if (own_rank_q < n) begin
      pos    = sorted_slot(own_rank_q, n);
      mirror = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (sorted_slot(j, n) == n - 1 - pos) mirror = j;
      end
      cur_l = rank_loads[own_rank_q];
      oth_l = rank_loads[mirror];
      min_l = round_min;
      max_l = round_max;
      ok    = 1'b1;
      if (!force_q) begin
        if (cur_l - min_l < min_abs_q) ok = 1'b0;
        if (ok) begin
          if (max_l == 0) ok = (min_rel_q == 0);
          else ok = (max_l - min_l) * 65536 >= min_rel_q * max_l;
        end
        if (ok && 2 * pos < n) ok = 1'b0;
        if (ok && (oth_l > cur_l || cur_l - oth_l < min_abs_q)) ok = 1'b0;
        if (ok && !(oth_l < cur_l && (cur_l - oth_l) * 65536 >= min_rel_q * cur_l)) ok = 1'b0;
      end
      if (ok) begin
        if (oth_l >= cur_l) num = 1;
        else num = ((cur_l - oth_l) * fraction_q) >> 16;
        if (num < 1) num = 1;
        if (num > 65535) num = 65535;
        d.offload = 1'b1;
        d.target  = mirror[OWN_W-1:0];
        d.tasks   = num[TASK_W-1:0];
      end
    end
    return d;
  endfunction

  function automatic void record_load(logic [LOAD_W-1:0] ld, logic lst);
    if (ranks_seen < DEF_MAX_RANKS) begin
      rank_loads[ranks_seen] = ld;
      ranks_seen++;
      if (ld < round_min) round_min = ld;
      if (ld > round_max) round_max = ld;
    end
    if (lst) begin
      pending_decisions.insert(pending_decisions.size(), decide_round());
      clear_round();
    end
  endfunction

  function automatic logic [LOAD_W-1:0] pick_load(int unsigned mode, logic [LOAD_W-1:0] base);
    case (mode)
      0: return LOAD_W'($urandom);
      1: return base + LOAD_W'($urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return LOAD_W'($urandom);
        endcase
      end
      default: return LOAD_W'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic load_settings(input logic [OWN_W-1:0] own, input logic [ABS_W-1:0] min_abs,
                               input logic [REL_W-1:0] min_rel, input logic [REL_W-1:0] frac,
                               input logic force_mig);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_OWN_RANK;
    cfg_wdata <= CFG_DATA_W'(own);
    @(posedge clk);
    cfg_idx   <= CFG_MIN_ABS;
    cfg_wdata <= CFG_DATA_W'(min_abs);
    @(posedge clk);
    cfg_idx   <= CFG_MIN_REL;
    cfg_wdata <= CFG_DATA_W'(min_rel);
    @(posedge clk);
    cfg_idx   <= CFG_FRACTION;
    cfg_wdata <= CFG_DATA_W'(frac);
    @(posedge clk);
    cfg_idx   <= CFG_FORCE;
    cfg_wdata <= CFG_DATA_W'(force_mig);
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_rank_q = own;
    min_abs_q  = min_abs;
    min_rel_q  = min_rel;
    fraction_q = frac;
    force_q    = force_mig;
  endtask

  task automatic send_load(input logic [LOAD_W-1:0] ld, input logic lst);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_load <= ld;
    in_last <= lst;
    do @(posedge clk); while (busy !== 1'b0);
    record_load(ld, lst);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_settings();
    send_load(16'd100, 1'b0);
    send_load(16'd10, 1'b1);
    send_load(16'd0, 1'b1);
    send_load(16'hFFFF, 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'd0, 1'b0);
    send_load(16'hFFFF, 1'b1);
    repeat (3) send_load(16'd5, 1'b0);
    send_load(16'd5, 1'b1);
    settle();
  endtask

  task automatic test_extreme_thresholds();
    load_settings(6'd0, 16'hFFFF, 17'd65536, 17'd65536, 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'd0, 1'b1);
    settle();
    load_settings(6'd0, 16'd0, 17'd0, 17'd0, 1'b0);
    send_load(16'd1, 1'b0);
    send_load(16'd0, 1'b1);
    send_load(16'd0, 1'b0);
    send_load(16'd0, 1'b1);
    settle();
  endtask

  task automatic test_forced_migration();
    load_settings(6'd0, 16'd2, 17'd6554, 17'd32768, 1'b1);
    send_load(16'd7, 1'b0);
    send_load(16'd3, 1'b0);
    send_load(16'd9, 1'b1);
    settle();
    load_settings(6'd1, 16'd2, 17'd6554, 17'd32768, 1'b1);
    send_load(16'd7, 1'b0);
    send_load(16'd3, 1'b0);
    send_load(16'd9, 1'b1);
    settle();
  endtask

  task automatic test_own_rank_past_round();
    load_settings(6'd63, 16'd0, 17'd0, 17'd32768, 1'b1);
    send_load(16'd1, 1'b0);
    send_load(16'd2, 1'b0);
    send_load(16'd3, 1'b1);
    settle();
  endtask

  task automatic test_store_overflow();
    load_settings(6'd63, 16'd0, 17'd0, 17'd65536, 1'b1);
    for (int i = 0; i < 66; i++) send_load(LOAD_W'($urandom), i == 65);
    settle();
  endtask

  task automatic test_random_rounds();
    int unsigned       phase_items;
    int unsigned       len;
    int unsigned       mode;
    logic [LOAD_W-1:0] base;
    logic [OWN_W-1:0]  own;
    logic [ABS_W-1:0]  min_abs;
    logic [REL_W-1:0]  min_rel;
    logic [REL_W-1:0]  frac;
    for (int phase = 0; phase < 10; phase++) begin
      own = ($urandom_range(0, 3) == 0) ? OWN_W'($urandom_range(0, 63))
                                        : OWN_W'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0: min_abs = '0;
        5: min_abs = MIN_ABS_RST;
        6: min_abs = ABS_W'($urandom);
        7: min_abs = '1;
        default: min_abs = ABS_W'($urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 7))
        0: min_rel = '0;
        5: min_rel = MIN_REL_RST;
        6: min_rel = REL_W'($urandom_range(0, 65536));
        7: min_rel = REL_W'(65536);
        default: min_rel = REL_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 3))
        0: frac = '0;
        1: frac = REL_W'(65536);
        default: frac = REL_W'($urandom_range(0, 65536));
      endcase
      load_settings(own, min_abs, min_rel, frac, $urandom_range(0, 3) == 0);
      steady_feed = (phase % 3 == 2);
      phase_items = 0;
      while (phase_items < 50) begin
        case ($urandom_range(0, 19))
          0: len = $urandom_range(60, 70);
          1: len = 1;
          default: len = $urandom_range(2, 12);
        endcase
        mode = $urandom_range(0, 3);
        base = LOAD_W'($urandom);
        for (int unsigned i = 0; i < len; i++) send_load(pick_load(mode, base), i == len - 1);
        phase_items += len;
      end
      settle();
    end
    steady_feed = 1'b0;
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_valid) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result, offload %0d target %0d tasks %0d", $time,
                 out_offload, out_target_rank, out_task_count);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_offload !== want.offload) begin
          $display("%0t: offload expected %0d actual %0d", $time, want.offload, out_offload);
          errors++;
        end
        if (out_target_rank !== want.target) begin
          $display("%0t: target_rank expected %0d actual %0d", $time, want.target,
                   out_target_rank);
          errors++;
        end
        if (out_task_count !== want.tasks) begin
          $display("%0t: task_count expected %0d actual %0d", $time, want.tasks,
                   out_task_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("[sorted_pair_offload_decider_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    own_rank_q = OWN_RANK_RST;
    min_abs_q  = MIN_ABS_RST;
    min_rel_q  = MIN_REL_RST;
    fraction_q = FRAC_RST;
    force_q    = 1'b0;
    clear_round();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_extreme_thresholds();
    test_forced_migration();
    test_own_rank_past_round();
    test_store_overflow();
    test_random_rounds();
    settle();
    if (errors == 0) begin
      $display("[sorted_pair_offload_decider_core] OK");
    end else begin
      $display("[sorted_pair_offload_decider_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
